FILE: rtl/column_juggle_synthesis_short_history_top_macros.svh
// Assertion macros for the subband juggle block.
// Used by the checker only; the clock and reset are named clk and rst_n.
`ifndef COLUMN_JUGGLE_SYNTHESIS_SHORT_HISTORY_TOP_MACROS_SVH
`define COLUMN_JUGGLE_SYNTHESIS_SHORT_HISTORY_TOP_MACROS_SVH

// Clocked property, disabled in reset.
`define CJS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Overlapping implication.
`define CJS_ASSERT_IMP(label, pre, post, msg) \
    `CJS_ASSERT(label, (pre) |-> (post), msg)

// Non-overlapping implication.
`define CJS_ASSERT_NXT(label, pre, post, msg) \
    `CJS_ASSERT(label, (pre) |=> (post), msg)

`endif

FILE: rtl/cjs_pkg.sv
// Shared types, constants and helpers for the subband juggle block.
// No dependencies.
`timescale 1ns / 1ps

package cjs_pkg;

    localparam int DATA_W      = 32;
    localparam int COL_W       = 11;
    localparam int ROW_W       = 8;
    localparam int HIST_W      = 16;
    localparam int HIST_DEPTH  = 2048;
    localparam int PAIRS_MAX   = 128;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);
    localparam int Q_CW        = $clog2(Q_DEPTH + 1);

    localparam logic [COL_W-1:0] CLR_LAST = COL_W'(HIST_DEPTH - 1);

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } front_state_t;

    // One classified word on its way from front to back.
    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic              row0;
        logic              odd;
        logic [HIST_W-1:0] hist_older;
        logic [HIST_W-1:0] hist_newer;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Last row index of a column, with the pair count clamped to 1..PAIRS_MAX.
    function automatic logic [ROW_W-1:0] last_row(input logic [ROW_W-1:0] pairs);
        logic [ROW_W-1:0] eff;
        logic [ROW_W-1:0] m;
        eff = pairs;
        if (pairs == '0)
            eff = ROW_W'(1);
        else if (pairs > ROW_W'(PAIRS_MAX))
            eff = ROW_W'(PAIRS_MAX);
        m = eff - ROW_W'(1);
        return {m[ROW_W-2:0], 1'b1};
    endfunction

    function automatic logic [DATA_W-1:0] sext_hist(input logic [HIST_W-1:0] h);
        return {{(DATA_W - HIST_W){h[HIST_W-1]}}, h};
    endfunction

endpackage

FILE: rtl/column_juggle_synthesis_short_history_top.sv
// Channel   Dir  Handshake              Payload
// in        in   in_valid / in_stall    sample[31:0] s, column[10:0], row[7:0]
// out       out  out_valid / out_stall  value[31:0] s
// cfg       in   cfg_we                 cfg_wdata[7:0] (row pairs)
//
// One word per cycle unless stalled; the output word is registered behind the queue.
// After reset the 2048-entry history RAM is cleared, one entry a cycle, with in_stall
// high; cfg writes are taken throughout.
// A four-word queue between front and back absorbs output stalls before in_stall rises.
// Top level; depends on cjs_pkg, cjs_front, cjs_queue, cjs_back.
`timescale 1ns / 1ps

module column_juggle_synthesis_short_history_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [cjs_pkg::DATA_W-1:0] sample,
    input  logic [cjs_pkg::COL_W-1:0]         column,
    input  logic [cjs_pkg::ROW_W-1:0]         row,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [cjs_pkg::DATA_W-1:0] value,
    input  logic                              cfg_we,
    input  logic [cjs_pkg::ROW_W-1:0]         cfg_wdata
);
    import cjs_pkg::*;

    q_stat_t q_stat;
    entry_t  push_entry;
    entry_t  head;
    logic    push;
    logic    pop;

    cjs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .column     (column),
        .row        (row),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    cjs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (head),
        .stat       (q_stat)
    );

    cjs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value)
    );

endmodule

FILE: rtl/cjs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cjs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/cjs_queue.sv
// Short FIFO of classified words between front and back.
// Depends on cjs_pkg.
`timescale 1ns / 1ps

module cjs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cjs_pkg::entry_t push_entry,
    input  logic            pop,
    output cjs_pkg::entry_t pop_entry,
    output cjs_pkg::q_stat_t stat
);
    import cjs_pkg::*;

    entry_t          slot_reg [Q_DEPTH];
    logic [Q_AW-1:0] wptr_reg;
    logic [Q_AW-1:0] wptr_next;
    logic [Q_AW-1:0] rptr_reg;
    logic [Q_AW-1:0] rptr_next;
    logic [Q_CW-1:0] count_reg;
    logic [Q_CW-1:0] count_next;

    always_comb
    begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_entry;
        end
    end

    assign pop_entry  = slot_reg[rptr_reg];
    assign stat.full  = (count_reg == Q_CW'(Q_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

FILE: rtl/cjs_front.sv
// Front end: takes words, keeps the column history store and classifies rows.
// Depends on cjs_pkg and cjs_ram.
`timescale 1ns / 1ps

module cjs_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [cjs_pkg::DATA_W-1:0] sample,
    input  logic [cjs_pkg::COL_W-1:0]   column,
    input  logic [cjs_pkg::ROW_W-1:0]   row,
    input  logic                        cfg_we,
    input  logic [cjs_pkg::ROW_W-1:0]   cfg_wdata,
    input  cjs_pkg::q_stat_t            q_stat,
    output logic                        push,
    output cjs_pkg::entry_t             push_entry
);
    import cjs_pkg::*;

    front_state_t      state_reg;
    front_state_t      state_next;
    logic              clearing;
    logic [COL_W-1:0]  clr_idx_reg;
    logic [COL_W-1:0]  clr_idx_next;
    logic [ROW_W-1:0]  row_pairs_reg;
    logic [DATA_W-1:0] prev_x_reg;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [DATA_W-1:0] s1_x_reg;
    logic              s1_row0_reg;
    logic              s1_odd_reg;
    logic              accept;
    logic              is_last;
    logic                       ram_we;
    logic [COL_W-1:0]           ram_waddr;
    logic [2*HIST_W-1:0]        ram_wdata;
    logic [2*HIST_W-1:0]        ram_rdata;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == CLR_LAST)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        clearing = 1'b0;
        unique case (state_reg)
            ST_CLEAR: clearing = 1'b1;
            ST_RUN:   clearing = 1'b0;
        endcase
    end

    assign in_stall      = clearing || (s1_valid_reg && q_stat.full);
    assign accept        = in_valid && !in_stall;
    assign push          = s1_valid_reg && !q_stat.full;
    assign is_last       = (row == last_row(row_pairs_reg));
    assign clr_idx_next  = clearing ? clr_idx_reg + 1'b1 : clr_idx_reg;
    assign s1_valid_next = accept ? 1'b1 : (push ? 1'b0 : s1_valid_reg);

    // history write: clearing pass, else the last two samples on a column's last row
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = column;
        ram_wdata = {prev_x_reg[HIST_W-1:0], sample[HIST_W-1:0]};
        if (clearing)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_idx_reg;
            ram_wdata = '0;
        end
        else if (accept && is_last)
        begin
            ram_we = 1'b1;
        end
    end

    cjs_ram #(
        .WIDTH (2 * HIST_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (column),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            row_pairs_reg <= ROW_W'(1);
            prev_x_reg    <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            s1_valid_reg <= s1_valid_next;
            if (cfg_we)
                row_pairs_reg <= cfg_wdata;
            if (accept)
                prev_x_reg <= sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg    <= sample;
            s1_row0_reg <= (row == '0);
            s1_odd_reg  <= row[0];
        end
    end

    assign push_entry.x          = s1_x_reg;
    assign push_entry.row0       = s1_row0_reg;
    assign push_entry.odd        = s1_odd_reg;
    assign push_entry.hist_older = ram_rdata[2*HIST_W-1:HIST_W];
    assign push_entry.hist_newer = ram_rdata[HIST_W-1:0];

endmodule

FILE: rtl/cjs_back.sv
// Back end: runs the reconstruction sums and holds the output word.
// Depends on cjs_pkg.
`timescale 1ns / 1ps

module cjs_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cjs_pkg::q_stat_t                   q_stat,
    input  cjs_pkg::entry_t                    head,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [cjs_pkg::DATA_W-1:0]  value
);
    import cjs_pkg::*;

    logic [DATA_W-1:0] prev_older_reg;
    logic [DATA_W-1:0] prev_newer_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] b2;
    logic [DATA_W-1:0] y;

    assign pop = !q_stat.empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        a  = head.row0 ? sext_hist(head.hist_older) : prev_older_reg;
        b  = head.row0 ? sext_hist(head.hist_newer) : prev_newer_reg;
        b2 = {b[DATA_W-2:0], 1'b0};
        y  = head.odd ? (b2 - a - head.x) : (a + b2 + head.x);
    end

    assign out_valid_next = pop ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_older_reg <= '0;
            prev_newer_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                prev_older_reg <= b;
                prev_newer_reg <= head.x;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            value_reg <= y;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

endmodule

FILE: rtl/cjs_checker.sv
// Port-level checker for the subband juggle top level, with its bind.
// Depends on the assertion macro header.
`timescale 1ns / 1ps
`include "column_juggle_synthesis_short_history_top_macros.svh"

module cjs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] value
);

    // stalled output word holds
    `CJS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(value), "output word changed under stall")

    // history clear runs straight after reset, nothing in flight
    `CJS_ASSERT_IMP(a_reset_clear, $rose(rst_n), in_stall && !out_valid, "not clearing after reset")

    // an accepted word reaches the output register
    `CJS_ASSERT_IMP(a_accept_out, in_valid && !in_stall, ##3 out_valid, "output missing after accept")

endmodule

bind column_juggle_synthesis_short_history_top cjs_checker u_cjs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value)
);
